FILE: rtl/core/ocpl_pkg.sv
package ocpl_pkg;

	localparam int CHANNELS = 3;
	localparam int CH_W = 2;
	localparam int DUTY_W = 7;
	localparam int CUR_W = 16;
	localparam int TIME_W = 32;
	localparam int LIMIT_W = 15;
	localparam int HYST_W = 7;
	localparam int DIVIDEND_W = LIMIT_W + DUTY_W;
	localparam int DIV_STEPS = DIVIDEND_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_HYST = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000);
	localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(1000);
	localparam logic [HYST_W-1:0] HYST_RST = HYST_W'(5);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_OVERCURRENT = 2'd1,
		MODE_LIMIT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_UPD
	} st_t;

	typedef struct packed {
		logic start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [CUR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DUTY_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/core/ocpl_div.sv
module ocpl_div
	import ocpl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [CUR_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CUR_W-1:0]      divisor_q;
	logic [CUR_W-1:0]      shifted;
	logic [CUR_W:0]        diff;

	assign shifted = {rem_q[CUR_W-2:0], quo_q[DIVIDEND_W-1]};
	assign diff = {1'b0, shifted} - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[CUR_W]) begin
				rem_q <= diff[CUR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q[DUTY_W-1:0];

endmodule

FILE: rtl/core/overcurrent_pwm_limiter_top.sv
// Over-current duty limiter for three heater channels.
// Input words arrive on the s_ stream: channel, commanded duty, signed current
// in milliamps and a millisecond time stamp. Each accepted word yields exactly
// one result word on the m_ stream: channel, duty to apply and channel mode.
// The block takes one word at a time and s_tready is low while it works, so a
// new word is accepted only after the previous result has been registered.
// A word that does not trip the limit passes through the multiply and update
// states to the result register; a word that trips it also runs the 22-step
// bit-serial divider that forms floor(limit * duty / current).
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; if the receiver holds m_tready low, the block
// holds the next result in its final step until the register is free.
// Limit, timeout and hysteresis are written over APB; the user must write
// them only while idle, as the block does not enforce it. Reset clears every
// channel to normal mode with zero safe duty and start time, and loads the
// registers with limit 1000 mA, timeout 1000 ms and a hysteresis of 5.
module overcurrent_pwm_limiter_top
	import ocpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,  // channel, commanded_duty, current_ma, now_ms
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,  // channel_out, duty_out, mode
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	st_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic [TIME_W-1:0]  timeout_q;
	logic [HYST_W-1:0]  hyst_q;

	logic [CH_W-1:0]       ch_q;
	logic [DUTY_W-1:0]     duty_q;
	logic [CUR_W-1:0]      cur_q;
	logic [TIME_W-1:0]     now_q;
	logic [DIVIDEND_W-1:0] prod_q;
	logic                  trig_q;
	logic [DUTY_W-1:0]     quot_q;

	logic                 oc_q  [CHANNELS];
	logic                 lim_q [CHANNELS];
	logic [DUTY_W-1:0]    sd_q  [CHANNELS];
	logic [TIME_W-1:0]    st_q  [CHANNELS];

	logic                 m_valid_q;
	logic [15:0]          m_data_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              accept;
	logic              cfg_wr;
	logic              ch_ok;
	logic [CH_W-1:0]   idx;
	logic              oc0, lim0, oc1, oc2, lim2, oc3, lim3;
	logic              trig;
	logic [DUTY_W-1:0] sd1;
	logic [TIME_W-1:0] st1;
	logic [TIME_W-1:0] elapsed;
	logic              tmo;
	logic signed [DUTY_W:0] floor_duty;
	logic              clr;
	logic              out_free;
	logic              upd;
	logic [DUTY_W-1:0] res_duty;
	mode_t             res_mode;

	ocpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			timeout_q <= TIMEOUT_RST;
			hyst_q <= HYST_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LIMIT:   limit_q <= pwdata[LIMIT_W-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIME_W-1:0];
				REG_HYST:    hyst_q <= pwdata[HYST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LIMIT:   prdata = {{(32-LIMIT_W){1'b0}}, limit_q};
			REG_TIMEOUT: prdata = timeout_q;
			REG_HYST:    prdata = {{(32-HYST_W){1'b0}}, hyst_q};
			default:     prdata = '0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign ch_ok = (int'(ch_q) < CHANNELS);
	assign idx = ch_ok ? ch_q : '0;
	assign oc0 = oc_q[idx];
	assign lim0 = lim_q[idx];
	assign trig = ($signed(cur_q) > $signed({1'b0, limit_q})) && !oc0 && !lim0;

	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor = cur_q;
		upd = 1'b0;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_MUL;
			ST_MUL:    state_d = (trig && ch_ok) ? ST_DSTART : ST_UPD;
			ST_DSTART: begin
				div_req.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV:    if (div_rsp.done) state_d = ST_UPD;
			ST_UPD: begin
				if (out_free) begin
					upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= s_tdata[1:0];
			duty_q <= s_tdata[8:2];
			cur_q <= s_tdata[24:9];
			now_q <= s_tdata[56:25];
		end
		if (state_q == ST_MUL) begin
			prod_q <= DIVIDEND_W'(limit_q * duty_q);
			trig_q <= trig && ch_ok;
			quot_q <= '0;
		end
		if (div_rsp.done) begin
			quot_q <= div_rsp.quotient;
		end
	end

	always_comb begin
		oc1 = oc0 || trig_q;
		sd1 = trig_q ? quot_q : sd_q[idx];
		st1 = trig_q ? now_q : st_q[idx];
		elapsed = now_q - st1;
		tmo = oc1 && (elapsed > timeout_q);
		oc2 = oc1 && !tmo;
		lim2 = lim0 || tmo;
		floor_duty = $signed({1'b0, sd1}) - $signed({1'b0, hyst_q});
		clr = (oc2 || lim2) &&
			(($signed({1'b0, duty_q}) < floor_duty) || (duty_q == '0));
		oc3 = oc2 && !clr;
		lim3 = lim2 && !clr;
		res_duty = duty_q;
		res_mode = MODE_NORMAL;
		if (ch_ok) begin
			if (lim3) begin
				res_duty = sd1;
				res_mode = MODE_LIMIT;
			end else if (oc3) begin
				res_mode = MODE_OVERCURRENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				oc_q[i] <= 1'b0;
				lim_q[i] <= 1'b0;
				sd_q[i] <= '0;
				st_q[i] <= '0;
			end
		end else if (upd && ch_ok) begin
			oc_q[idx] <= oc3;
			lim_q[idx] <= lim3;
			sd_q[idx] <= sd1;
			st_q[idx] <= st1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (upd) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			m_data_q <= {5'd0, res_mode, res_duty, ch_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

FILE: tb/sv/tb_overcurrent_pwm_limiter_top.sv
`timescale 1ns / 100ps

module tb_overcurrent_pwm_limiter_top;
	import ocpl_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int RANDOM_PHASES = 6;

	// The first declared member sits in the highest bits.
	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic signed [CUR_W-1:0] current_ma;
		logic [DUTY_W-1:0] duty;
		logic [CH_W-1:0] channel;
	} sample_t;

	typedef struct packed {
		mode_t mode;
		logic [DUTY_W-1:0] duty;
		logic [CH_W-1:0] channel;
	} duty_word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;  // channel, commanded_duty, current_ma, now_ms
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;  // channel_out, duty_out, mode
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	logic [TIME_W-1:0] clock_ms;

	overcurrent_pwm_limiter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	class duty_limit_scoreboard;
		logic [LIMIT_W-1:0] limit_ma;
		logic [TIME_W-1:0] timeout_ms;
		logic [HYST_W-1:0] hyst;
		logic oc_flag [CHANNELS];
		logic lim_flag [CHANNELS];
		logic [DUTY_W-1:0] safe_duty [CHANNELS];
		logic [TIME_W-1:0] start_ms [CHANNELS];
		duty_word_t predicted_words [$];
		int failures;

		function new();
			limit_ma = LIMIT_RST;
			timeout_ms = TIMEOUT_RST;
			hyst = HYST_RST;
			failures = 0;
			foreach (oc_flag[i]) begin
				oc_flag[i] = 1'b0;
				lim_flag[i] = 1'b0;
				safe_duty[i] = '0;
				start_ms[i] = '0;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_LIMIT: limit_ma = value[LIMIT_W-1:0];
				REG_TIMEOUT: timeout_ms = value[TIME_W-1:0];
				REG_HYST: hyst = value[HYST_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t smp);
			int c;
			int cur;
			logic [31:0] quot;
			logic [TIME_W-1:0] elapsed;
			duty_word_t word;
			word.channel = smp.channel;
			word.duty = smp.duty;
			word.mode = MODE_NORMAL;
			cur = $signed(smp.current_ma);
			if (smp.channel < CHANNELS) begin
				c = smp.channel;
				if (cur > int'(limit_ma) && !oc_flag[c] && !lim_flag[c]) begin
					quot = (32'(limit_ma) * 32'(smp.duty)) / 32'(cur);
					safe_duty[c] = quot[DUTY_W-1:0];
					start_ms[c] = smp.now_ms;
					oc_flag[c] = 1'b1;
				end
				elapsed = smp.now_ms - start_ms[c];
				if (oc_flag[c] && elapsed > timeout_ms) begin
					oc_flag[c] = 1'b0;
					lim_flag[c] = 1'b1;
				end
				if (oc_flag[c] || lim_flag[c]) begin
					if (int'(smp.duty) < int'(safe_duty[c]) - int'(hyst) || smp.duty == 0) begin
						oc_flag[c] = 1'b0;
						lim_flag[c] = 1'b0;
					end
				end
				if (lim_flag[c]) begin
					word.duty = safe_duty[c];
					word.mode = MODE_LIMIT;
				end else if (oc_flag[c]) begin
					word.mode = MODE_OVERCURRENT;
				end
			end
			predicted_words.push_back(word);
		endfunction

		function void check_word(logic [15:0] data);
			duty_word_t got;
			duty_word_t want;
			got = data[10:0];
			if (predicted_words.size() == 0) begin
				$error("result word with no expectation waiting: %h", data);
				failures++;
				return;
			end
			want = predicted_words.pop_front();
			if (got.channel !== want.channel) begin
				$error("channel_out expected %0d got %0d", want.channel, got.channel);
				failures++;
			end
			if (got.duty !== want.duty) begin
				$error("duty_out expected %0d got %0d", want.duty, got.duty);
				failures++;
			end
			if (got.mode !== want.mode) begin
				$error("mode expected %0d got %0d", want.mode, got.mode);
				failures++;
			end
		endfunction
	endclass

	duty_limit_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_word(m_tdata);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic sample_t make_sample(int ch, int duty, int cur, logic [31:0] now);
		sample_t smp;
		smp.channel = CH_W'(ch);
		smp.duty = DUTY_W'(duty);
		smp.current_ma = CUR_W'(cur);
		smp.now_ms = now;
		return smp;
	endfunction

	function automatic sample_t random_sample();
		int lim;
		int ch;
		int duty;
		int cur;
		int r;
		lim = int'(sb.limit_ma);
		ch = ($urandom_range(0, 15) == 0) ? 3 : int'($urandom_range(0, CHANNELS - 1));
		r = $urandom_range(0, 99);
		if (r < 70)
			duty = $urandom_range(1, 100);
		else if (r < 78)
			duty = 0;
		else if (r < 88)
			duty = $urandom_range(101, 127);
		else
			duty = $urandom_range(0, 15);
		r = $urandom_range(0, 99);
		if (r < 25)
			cur = lim + int'($urandom_range(1, lim / 2 + 20));
		else if (r < 40)
			cur = int'($urandom_range(lim, 32767)) + 1;
		else if (r < 65)
			cur = $urandom_range(0, lim);
		else if (r < 75)
			cur = -int'($urandom_range(1, 32768));
		else if (r < 80)
			cur = lim;
		else
			cur = $urandom_range(0, 65535);
		if (r < 40 && cur > 32767)
			cur = 32767;
		r = $urandom_range(0, 99);
		if (r < 88)
			clock_ms = clock_ms + $urandom_range(0, 12);
		else if (r < 96)
			clock_ms = clock_ms + $urandom;
		return make_sample(ch, duty, cur, clock_ms);
	endfunction

	task automatic send_sample(sample_t smp);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(smp);
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.predicted_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(int lim, logic [31:0] timeout, int hyst_val);
		wait_all_results();
		apb_write(REG_LIMIT, 32'(lim));
		apb_write(REG_TIMEOUT, timeout);
		apb_write(REG_HYST, 32'(hyst_val));
	endtask

	task automatic run_directed();
		send_sample(make_sample(0, 50, 2000, 100));
		send_sample(make_sample(0, 50, 2000, 1100));
		send_sample(make_sample(0, 50, 0, 1101));
		send_sample(make_sample(0, 20, 0, 1102));
		send_sample(make_sample(0, 19, 0, 1103));
		send_sample(make_sample(1, 127, 32767, 32'hFFFF_FFF0));
		send_sample(make_sample(1, 127, 500, 32'h0000_0100));
		send_sample(make_sample(1, 0, 32767, 32'h0000_03E0));
		send_sample(make_sample(2, 100, -32768, 5));
		send_sample(make_sample(2, 100, 1000, 6));
		send_sample(make_sample(2, 100, 1001, 10));
		send_sample(make_sample(3, 77, 5000, 0));
		send_sample(make_sample(3, 127, -1, 32'hFFFF_FFFF));
		send_sample(make_sample(2, 0, 0, 20));
		send_sample(make_sample(0, 1, 32767, 0));
		send_sample(make_sample(0, 1, 32767, 32'h8000_0000));
		send_sample(make_sample(0, 120, 0, 32'h8000_0001));
		send_sample(make_sample(0, 0, 0, 32'h8000_0002));
		send_sample(make_sample(1, 85, 16'h5555, 32'h5555_5555));
		send_sample(make_sample(2, 42, 16'h2AAA, 32'hAAAA_AAAA));
		send_sample(make_sample(1, 3, 0, 32'hAAAA_AAAA));
		send_sample(make_sample(2, 101, 1, 32'hAAAA_AAAB));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 8;
		recv_stall_pct = 67;
		clock_ms = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: configure(1000, 20, 5);
				2: configure(1, 0, 0);
				3: configure(32767, 32'hFFFF_FFFF, 100);
				4: configure(0, 5, 10);
				5: configure($urandom_range(1, 32767), $urandom_range(0, 200),
					$urandom_range(0, 100));
				default: configure(500, 1000, 3);
			endcase
			if (p <= 2) begin
				send_idle_pct = 8;
				recv_stall_pct = 67;
			end else if (p <= 4) begin
				send_idle_pct = 67;
				recv_stall_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if (p == 2)
				clock_ms = 32'hFFFF_FF80;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_sample(random_sample());
		end

		wait_all_results();
		repeat (30) @(posedge clk);
		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ocpl_pkg.sv
rtl/core/ocpl_div.sv
rtl/core/overcurrent_pwm_limiter_top.sv
tb/sv/tb_overcurrent_pwm_limiter_top.sv
